/* rtl/tape_flutter_delay_macros.svh */
// Assertion helpers for the delay line RTL.
`ifndef TAPE_FLUTTER_DELAY_MACROS_SVH
`define TAPE_FLUTTER_DELAY_MACROS_SVH

// Condition implies property in the same cycle.
`define TFD_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Condition implies property in the next cycle.
`define TFD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/tfd_pkg.sv */
package tfd_pkg;

  localparam int AW = 12;
  localparam int DEPTH = 1 << AW;
  localparam int SW = 24;
  localparam int NOMINAL = 512;
  localparam int SINE_BITS = 10;
  localparam int FRAC = 16;
  localparam int POS_W = AW + FRAC;

  localparam int MA = 36;
  localparam int MB = 25;
  localparam int MP = MA + MB;
  localparam int ACC_W = 44;
  localparam int OFS_W = 28;
  localparam int WT_W = 19;

  localparam logic [16:0] SIN_C1 = 17'd51472;
  localparam logic [16:0] SIN_C3 = 17'd21167;
  localparam logic [16:0] SIN_C5 = 17'd2611;
  localparam logic [16:0] SIN_MAX = 17'd32767;
  localparam logic [16:0] QUARTER = 17'd32768;
  localparam logic [17:0] RECIP3 = 18'd43691;
  localparam logic [16:0] DEPTH_ONE = 17'd65536;

  localparam logic [31:0] LEFT_SEED = 32'h9E3779B9;
  localparam logic [31:0] RIGHT_SEED = 32'h85EBCA6B;
  localparam logic [31:0] SCRAPE_SEED = 32'hC2B2AE35;

  localparam logic signed [MP-1:0] DLY_NOM = MP'(NOMINAL) <<< FRAC;
  localparam logic signed [MP-1:0] DLY_MIN = MP'(2) <<< FRAC;
  localparam logic signed [MP-1:0] DLY_MAX = MP'(DEPTH - 3) <<< FRAC;

  localparam logic [3:0] REG_TONE0_STEP = 4'd0;
  localparam logic [3:0] REG_TONE0_AMP = 4'd1;
  localparam logic [3:0] REG_TONE1_STEP = 4'd2;
  localparam logic [3:0] REG_TONE1_AMP = 4'd3;
  localparam logic [3:0] REG_SCRAPE_AMP = 4'd4;
  localparam logic [3:0] REG_SCRAPE_COEF = 4'd5;
  localparam logic [3:0] REG_DEPTH = 4'd6;
  localparam logic [3:0] REG_HISS_GAIN = 4'd7;

  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  // Arithmetic right shift that rounds toward zero.
  function automatic logic signed [MP-1:0] tz(input logic signed [MP-1:0] p, input int sh);
    logic signed [MP-1:0] one;
    logic signed [MP-1:0] bias;
    one = {{(MP-1){1'b0}}, 1'b1};
    bias = p[MP-1] ? ((one <<< sh) - one) : '0;
    return (p + bias) >>> sh;
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [MP-1:0] v);
    logic signed [MP-1:0] hi;
    logic signed [MP-1:0] lo;
    hi = {{(MP-SW+1){1'b0}}, {(SW-1){1'b1}}};
    lo = {{(MP-SW+1){1'b1}}, {(SW-1){1'b0}}};
    if (v > hi) begin
      return hi[SW-1:0];
    end else if (v < lo) begin
      return lo[SW-1:0];
    end
    return v[SW-1:0];
  endfunction

endpackage

/* rtl/tfd_ram.sv */
module tfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tape_flutter_delay.sv */
// Items are processed one at a time: a new item is accepted only in the idle state,
// after the previous result has been placed on the output. One shared 36x25 multiplier
// does every product of the sine, scrape, delay, weight and tap math in turn.
// Reset: synchronous, active high. After reset a clearing pass zeroes both delay
// stores; no item is accepted during it, configuration writes are.
`include "tape_flutter_delay_macros.svh"

module tape_flutter_delay (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [3:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [23:0]      left_in,
  input  logic signed [23:0]      right_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [23:0]      left_out,
  output logic signed [23:0]      right_out
);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_PREP  = 6'd1;
  localparam logic [5:0] S_SQ    = 6'd2;
  localparam logic [5:0] S_SQW   = 6'd3;
  localparam logic [5:0] S_P3    = 6'd4;
  localparam logic [5:0] S_P3W   = 6'd5;
  localparam logic [5:0] S_P1    = 6'd6;
  localparam logic [5:0] S_P1W   = 6'd7;
  localparam logic [5:0] S_SIN   = 6'd8;
  localparam logic [5:0] S_SINW  = 6'd9;
  localparam logic [5:0] S_OFS   = 6'd10;
  localparam logic [5:0] S_FILT  = 6'd11;
  localparam logic [5:0] S_FILTW = 6'd12;
  localparam logic [5:0] S_SCR   = 6'd13;
  localparam logic [5:0] S_SCRW  = 6'd14;
  localparam logic [5:0] S_DEP   = 6'd15;
  localparam logic [5:0] S_DEPW  = 6'd16;
  localparam logic [5:0] S_POS   = 6'd17;
  localparam logic [5:0] S_A01   = 6'd18;
  localparam logic [5:0] S_B     = 6'd19;
  localparam logic [5:0] S_W0V   = 6'd20;
  localparam logic [5:0] S_W1    = 6'd21;
  localparam logic [5:0] S_W0    = 6'd22;
  localparam logic [5:0] S_C     = 6'd23;
  localparam logic [5:0] S_CW    = 6'd24;
  localparam logic [5:0] S_W2    = 6'd25;
  localparam logic [5:0] S_W3V   = 6'd26;
  localparam logic [5:0] S_W3VW  = 6'd27;
  localparam logic [5:0] S_W3    = 6'd28;
  localparam logic [5:0] S_W3W   = 6'd29;
  localparam logic [5:0] S_TL    = 6'd30;
  localparam logic [5:0] S_TR    = 6'd31;
  localparam logic [5:0] S_TN    = 6'd32;
  localparam logic [5:0] S_TWAIT = 6'd33;
  localparam logic [5:0] S_RES   = 6'd34;
  localparam logic [5:0] S_HL    = 6'd35;
  localparam logic [5:0] S_HR    = 6'd36;
  localparam logic [5:0] S_HW    = 6'd37;
  localparam logic [5:0] S_DONE  = 6'd38;

  localparam logic [4:0] M_NONE = 5'd0;
  localparam logic [4:0] M_T2   = 5'd1;
  localparam logic [4:0] M_P3   = 5'd2;
  localparam logic [4:0] M_P1   = 5'd3;
  localparam logic [4:0] M_SIN  = 5'd4;
  localparam logic [4:0] M_OFS  = 5'd5;
  localparam logic [4:0] M_FILT = 5'd6;
  localparam logic [4:0] M_SCR  = 5'd7;
  localparam logic [4:0] M_DEP  = 5'd8;
  localparam logic [4:0] M_A01  = 5'd9;
  localparam logic [4:0] M_B    = 5'd10;
  localparam logic [4:0] M_W0V  = 5'd11;
  localparam logic [4:0] M_W1   = 5'd12;
  localparam logic [4:0] M_W0   = 5'd13;
  localparam logic [4:0] M_C    = 5'd14;
  localparam logic [4:0] M_W2   = 5'd15;
  localparam logic [4:0] M_W3V  = 5'd16;
  localparam logic [4:0] M_W3   = 5'd17;
  localparam logic [4:0] M_TL   = 5'd18;
  localparam logic [4:0] M_TR   = 5'd19;
  localparam logic [4:0] M_HL   = 5'd20;
  localparam logic [4:0] M_HR   = 5'd21;

  localparam int AW = tfd_pkg::AW;
  localparam int MA = tfd_pkg::MA;
  localparam int MB = tfd_pkg::MB;
  localparam int MP = tfd_pkg::MP;
  localparam int SW = tfd_pkg::SW;
  localparam int WT_W = tfd_pkg::WT_W;
  localparam int OFS_W = tfd_pkg::OFS_W;
  localparam int ACC_W = tfd_pkg::ACC_W;
  localparam int POS_W = tfd_pkg::POS_W;
  localparam int FRAC = tfd_pkg::FRAC;
  localparam int WB = tfd_pkg::SINE_BITS - 2;

  logic [31:0] tone_step [2];
  logic [23:0] tone_amp [2];
  logic [23:0] scrape_amp;
  logic [15:0] scrape_coef;
  logic [16:0] depth;
  logic [15:0] hiss_gain;

  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  logic [5:0]    state;
  logic [4:0]    mop;
  logic [4:0]    mop_next;
  logic          k;
  logic [1:0]    j;
  logic [AW-1:0] wpos;
  logic [31:0]   phase [2];
  logic [31:0]   lseed;
  logic [31:0]   rseed;
  logic [31:0]   sseed;
  logic signed [SW-1:0] filt;

  logic [1:0]  quad;
  logic [16:0] t15;
  logic [16:0] t2;
  logic [16:0] pp;
  logic signed [16:0] sine;
  logic signed [OFS_W-1:0] ofs;
  logic [POS_W-1:0] dly;
  logic [AW-1:0] base;
  logic [15:0] f;
  logic signed [MA-1:0] a01;
  logic signed [MA-1:0] bb;
  logic signed [MA-1:0] cc;
  logic signed [WT_W-1:0] v0;
  logic signed [WT_W-1:0] v3;
  logic signed [WT_W-1:0] w [4];
  logic signed [ACC_W-1:0] accl;
  logic signed [ACC_W-1:0] accr;
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] ro;

  logic signed [MA-1:0] ma;
  logic signed [MB-1:0] mb;
  logic signed [MP-1:0] prod;

  logic signed [17:0] fs;
  logic signed [17:0] fm1;
  logic signed [17:0] fm2;
  logic signed [17:0] fp1;
  logic signed [WT_W-1:0] v0_abs;
  logic signed [WT_W-1:0] v3_abs;
  logic signed [SW:0] ndiff;
  logic signed [SW-1:0] snoise;
  logic [POS_W-1:0] pos;
  logic [WB-1:0] wsel;
  logic signed [MP-1:0] sh_val;
  logic signed [MP-1:0] dly_full;
  logic [16:0] s_q;
  logic [WT_W-1:0] q3;

  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wl;
  logic [SW-1:0] ram_wr;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rl;
  logic [SW-1:0] ram_rr;

  assign in_ready = (state == S_IDLE) && !clr_busy;
  assign accept = in_valid && in_ready;

  assign ram_we = clr_busy || accept;
  assign ram_waddr = clr_busy ? clr_addr : wpos;
  assign ram_wl = clr_busy ? '0 : left_in;
  assign ram_wr = clr_busy ? '0 : right_in;
  assign ram_raddr = base + AW'(j) - AW'(1);

  tfd_ram #(.WIDTH(SW), .DEPTH(tfd_pkg::DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wl),
    .raddr (ram_raddr),
    .rdata (ram_rl)
  );

  tfd_ram #(.WIDTH(SW), .DEPTH(tfd_pkg::DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rr)
  );

  assign fs = {2'b00, f};
  assign fm1 = fs - 18'sd65536;
  assign fm2 = fs - 18'sh20000;
  assign fp1 = fs + 18'sd65536;
  assign v0_abs = v0[WT_W-1] ? -v0 : v0;
  assign v3_abs = v3[WT_W-1] ? -v3 : v3;
  assign snoise = sseed[31:32-SW];
  assign ndiff = {snoise[SW-1], snoise} - {filt[SW-1], filt};
  assign pos = {wpos - AW'(1), {FRAC{1'b0}}} - dly;
  assign wsel = phase[k][29:30-WB];

  always_comb begin
    ma = '0;
    mb = '0;
    mop_next = M_NONE;
    unique case (state)
      S_SQ: begin
        ma = {{(MA-17){1'b0}}, t15};
        mb = {{(MB-17){1'b0}}, t15};
        mop_next = M_T2;
      end
      S_P3: begin
        ma = {{(MA-17){1'b0}}, t2};
        mb = {{(MB-17){1'b0}}, tfd_pkg::SIN_C5};
        mop_next = M_P3;
      end
      S_P1: begin
        ma = {{(MA-17){1'b0}}, t2};
        mb = {{(MB-17){1'b0}}, pp};
        mop_next = M_P1;
      end
      S_SIN: begin
        ma = {{(MA-17){1'b0}}, t15};
        mb = {{(MB-17){1'b0}}, pp};
        mop_next = M_SIN;
      end
      S_OFS: begin
        ma = {{(MA-24){1'b0}}, tone_amp[k]};
        mb = {{(MB-17){sine[16]}}, sine};
        mop_next = M_OFS;
      end
      S_FILT: begin
        ma = {{(MA-SW-1){ndiff[SW]}}, ndiff};
        mb = {{(MB-16){1'b0}}, scrape_coef};
        mop_next = M_FILT;
      end
      S_SCR: begin
        ma = {{(MA-24){1'b0}}, scrape_amp};
        mb = {{(MB-SW){filt[SW-1]}}, filt};
        mop_next = M_SCR;
      end
      S_DEP: begin
        ma = {{(MA-OFS_W){ofs[OFS_W-1]}}, ofs};
        mb = {{(MB-17){1'b0}}, depth};
        mop_next = M_DEP;
      end
      S_A01: begin
        ma = {{(MA-18){fs[17]}}, fs};
        mb = {{(MB-18){fm1[17]}}, fm1};
        mop_next = M_A01;
      end
      S_B: begin
        ma = {{(MA-18){fp1[17]}}, fp1};
        mb = {{(MB-18){fm1[17]}}, fm1};
        mop_next = M_B;
      end
      S_W0V: begin
        ma = a01;
        mb = {{(MB-18){fm2[17]}}, fm2};
        mop_next = M_W0V;
      end
      S_W1: begin
        ma = bb;
        mb = {{(MB-18){fm2[17]}}, fm2};
        mop_next = M_W1;
      end
      S_W0: begin
        ma = {{(MA-WT_W){v0_abs[WT_W-1]}}, v0_abs};
        mb = {{(MB-18){1'b0}}, tfd_pkg::RECIP3};
        mop_next = M_W0;
      end
      S_C: begin
        ma = {{(MA-18){fp1[17]}}, fp1};
        mb = {{(MB-18){fs[17]}}, fs};
        mop_next = M_C;
      end
      S_W2: begin
        ma = cc;
        mb = {{(MB-18){fm2[17]}}, fm2};
        mop_next = M_W2;
      end
      S_W3V: begin
        ma = cc;
        mb = {{(MB-18){fm1[17]}}, fm1};
        mop_next = M_W3V;
      end
      S_W3: begin
        ma = {{(MA-WT_W){v3_abs[WT_W-1]}}, v3_abs};
        mb = {{(MB-18){1'b0}}, tfd_pkg::RECIP3};
        mop_next = M_W3;
      end
      S_TL: begin
        ma = {{(MA-SW){ram_rl[SW-1]}}, ram_rl};
        mb = {{(MB-WT_W){w[j][WT_W-1]}}, w[j]};
        mop_next = M_TL;
      end
      S_TR: begin
        ma = {{(MA-SW){ram_rr[SW-1]}}, ram_rr};
        mb = {{(MB-WT_W){w[j][WT_W-1]}}, w[j]};
        mop_next = M_TR;
      end
      S_HL: begin
        ma = {{(MA-SW){lseed[31]}}, lseed[31:32-SW]};
        mb = {{(MB-16){1'b0}}, hiss_gain};
        mop_next = M_HL;
      end
      S_HR: begin
        ma = {{(MA-SW){rseed[31]}}, rseed[31:32-SW]};
        mb = {{(MB-16){1'b0}}, hiss_gain};
        mop_next = M_HR;
      end
      default: begin
        mop_next = M_NONE;
      end
    endcase
  end

  always_comb begin
    sh_val = '0;
    unique case (mop)
      M_OFS:                sh_val = tfd_pkg::tz(prod, 15);
      M_FILT, M_DEP, M_HL,
      M_HR:                 sh_val = tfd_pkg::tz(prod, 16);
      M_SCR:                sh_val = tfd_pkg::tz(prod, SW - 1);
      M_W0V, M_W1, M_W2,
      M_W3V:                sh_val = tfd_pkg::tz(prod, 33);
      default:              sh_val = prod >>> 15;
    endcase
  end

  assign dly_full = tfd_pkg::DLY_NOM + sh_val;
  assign s_q = (sh_val > MP'(tfd_pkg::SIN_MAX)) ? tfd_pkg::SIN_MAX : sh_val[16:0];
  assign q3 = prod[17+WT_W-1:17];

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_step[0] <= '0;
      tone_step[1] <= '0;
      tone_amp[0] <= '0;
      tone_amp[1] <= '0;
      scrape_amp <= '0;
      scrape_coef <= '0;
      depth <= '0;
      hiss_gain <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tfd_pkg::REG_TONE0_STEP:  tone_step[0] <= cfg_data;
        tfd_pkg::REG_TONE0_AMP:   tone_amp[0] <= cfg_data[23:0];
        tfd_pkg::REG_TONE1_STEP:  tone_step[1] <= cfg_data;
        tfd_pkg::REG_TONE1_AMP:   tone_amp[1] <= cfg_data[23:0];
        tfd_pkg::REG_SCRAPE_AMP:  scrape_amp <= cfg_data[23:0];
        tfd_pkg::REG_SCRAPE_COEF: scrape_coef <= cfg_data[15:0];
        tfd_pkg::REG_DEPTH: begin
          depth <= (cfg_data[16:0] > tfd_pkg::DEPTH_ONE) ? tfd_pkg::DEPTH_ONE
                                                          : cfg_data[16:0];
        end
        tfd_pkg::REG_HISS_GAIN:   hiss_gain <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == {AW{1'b1}}) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (mop)
      M_T2:   t2 <= sh_val[16:0];
      M_P3:   pp <= tfd_pkg::SIN_C3 - sh_val[16:0];
      M_P1:   pp <= tfd_pkg::SIN_C1 - sh_val[16:0];
      M_SIN:  sine <= quad[1] ? -$signed(s_q) : $signed(s_q);
      M_OFS,
      M_SCR:  ofs <= ofs + sh_val[OFS_W-1:0];
      M_DEP: begin
        if (dly_full < tfd_pkg::DLY_MIN) begin
          dly <= tfd_pkg::DLY_MIN[POS_W-1:0];
        end else if (dly_full > tfd_pkg::DLY_MAX) begin
          dly <= tfd_pkg::DLY_MAX[POS_W-1:0];
        end else begin
          dly <= dly_full[POS_W-1:0];
        end
      end
      M_A01:  a01 <= prod[MA-1:0];
      M_B:    bb <= prod[MA-1:0];
      M_W0V:  v0 <= -sh_val[WT_W-1:0];
      M_W1:   w[1] <= sh_val[WT_W-1:0];
      M_W0:   w[0] <= v0[WT_W-1] ? -$signed(q3) : $signed(q3);
      M_C:    cc <= prod[MA-1:0];
      M_W2:   w[2] <= -sh_val[WT_W-1:0];
      M_W3V:  v3 <= sh_val[WT_W-1:0];
      M_W3:   w[3] <= v3[WT_W-1] ? -$signed(q3) : $signed(q3);
      M_TL:   accl <= accl + prod[ACC_W-1:0];
      M_TR:   accr <= accr + prod[ACC_W-1:0];
      M_HL:   lo <= tfd_pkg::sat(MP'(lo) + sh_val);
      M_HR:   ro <= tfd_pkg::sat(MP'(ro) + sh_val);
      default: begin
      end
    endcase
    if (rst) begin
      filt <= '0;
    end else if (mop == M_FILT) begin
      filt <= tfd_pkg::sat(MP'(filt) + sh_val);
    end
    unique case (state)
      S_IDLE: begin
        ofs <= '0;
      end
      S_PREP: begin
        quad <= phase[k][31:30];
        t15 <= phase[k][30] ? tfd_pkg::QUARTER - 17'({wsel, {(15-WB){1'b0}}})
                            : 17'({wsel, {(15-WB){1'b0}}});
      end
      S_POS: begin
        base <= pos[POS_W-1:FRAC];
        f <= pos[FRAC-1:0];
        accl <= '0;
        accr <= '0;
      end
      S_RES: begin
        lo <= tfd_pkg::sat(tfd_pkg::tz(MP'(accl), FRAC));
        ro <= tfd_pkg::sat(tfd_pkg::tz(MP'(accr), FRAC));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mop <= M_NONE;
      k <= 1'b0;
      j <= '0;
      wpos <= '0;
      phase[0] <= '0;
      phase[1] <= '0;
      lseed <= tfd_pkg::LEFT_SEED;
      rseed <= tfd_pkg::RIGHT_SEED;
      sseed <= tfd_pkg::SCRAPE_SEED;
      out_valid <= 1'b0;
    end else begin
      mop <= mop_next;
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            wpos <= wpos + AW'(1);
            sseed <= tfd_pkg::xorshift(sseed);
            k <= 1'b0;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          phase[k] <= phase[k] + tone_step[k];
          state <= S_SQ;
        end
        S_SQ:    state <= S_SQW;
        S_SQW:   state <= S_P3;
        S_P3:    state <= S_P3W;
        S_P3W:   state <= S_P1;
        S_P1:    state <= S_P1W;
        S_P1W:   state <= S_SIN;
        S_SIN:   state <= S_SINW;
        S_SINW:  state <= S_OFS;
        S_OFS: begin
          if (!k) begin
            k <= 1'b1;
            state <= S_PREP;
          end else begin
            state <= S_FILT;
          end
        end
        S_FILT:  state <= S_FILTW;
        S_FILTW: state <= S_SCR;
        S_SCR:   state <= S_SCRW;
        S_SCRW:  state <= S_DEP;
        S_DEP:   state <= S_DEPW;
        S_DEPW:  state <= S_POS;
        S_POS: begin
          j <= '0;
          state <= S_A01;
        end
        S_A01:   state <= S_B;
        S_B:     state <= S_W0V;
        S_W0V:   state <= S_W1;
        S_W1:    state <= S_W0;
        S_W0:    state <= S_C;
        S_C:     state <= S_CW;
        S_CW:    state <= S_W2;
        S_W2:    state <= S_W3V;
        S_W3V:   state <= S_W3VW;
        S_W3VW:  state <= S_W3;
        S_W3:    state <= S_W3W;
        S_W3W:   state <= S_TL;
        S_TL:    state <= S_TR;
        S_TR:    state <= S_TN;
        S_TN: begin
          j <= j + 2'd1;
          state <= S_TWAIT;
        end
        S_TWAIT: state <= (j == 2'd0) ? S_RES : S_TL;
        S_RES: begin
          if (hiss_gain != '0) begin
            lseed <= tfd_pkg::xorshift(lseed);
            rseed <= tfd_pkg::xorshift(rseed);
            state <= S_HL;
          end else begin
            state <= S_DONE;
          end
        end
        S_HL:    state <= S_HR;
        S_HR:    state <= S_HW;
        S_HW:    state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            left_out <= lo;
            right_out <= ro;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TFD_ASSERT_NOW(a_no_accept_while_clearing, clr_busy, !in_ready,
                  "item accepted during the clearing pass")
  `TFD_ASSERT_NEXT(a_accept_starts_work, accept,
                   state == S_PREP && wpos == AW'($past(wpos) + AW'(1)),
                   "accepted item did not start work or advance the write position")
  `TFD_ASSERT_NEXT(a_done_presents_result, state == S_DONE && (!out_valid || out_ready),
                   out_valid && state == S_IDLE,
                   "finished item was not presented")

endmodule

/* tb/tape_flutter_delay_test.sv */
module tape_flutter_delay_test;

  localparam int LIMIT = 1000000;
  localparam int SETTLE = 80;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } stereo_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] left_in = '0;
  logic signed [23:0] right_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] left_out;
  logic signed [23:0] right_out;

  tape_flutter_delay dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .left_in(left_in), .right_in(right_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_out(left_out), .right_out(right_out)
  );

  // Shadow copy of the delay line.
  logic [31:0] step_mirror [2];
  longint amp_mirror [2];
  longint scrape_amp_mirror, scrape_coef_mirror, depth_mirror, hiss_mirror;
  logic signed [23:0] left_tape [tfd_pkg::DEPTH];
  logic signed [23:0] right_tape [tfd_pkg::DEPTH];
  logic [11:0] head_pos;
  logic [31:0] phase_mirror [2];
  longint scrape_lp;
  logic [31:0] left_seed, right_seed, scrape_seed;

  stereo_t pending_pairs [$];
  int errors = 0;
  int items_sent = 0;
  int pairs_checked = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(negedge clk) begin
    stereo_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected item: left %0d right %0d", left_out, right_out);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (left_out !== want.left) begin
          $error("left_out: expected %0d, actual %0d", want.left, left_out);
          errors++;
        end
        if (right_out !== want.right) begin
          $error("right_out: expected %0d, actual %0d", want.right, right_out);
          errors++;
        end
        pairs_checked++;
      end
    end
  end

  function automatic longint clip24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint mul_tz(longint a, longint b, int sh);
    return (a * b) / (longint'(1) << sh);
  endfunction

  function automatic longint xorshift_draw(inout logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    s = x;
    return longint'($signed(x[31:8]));
  endfunction

  function automatic longint sine_of(logic [31:0] ph);
    longint unsigned idx, t, t15, t2, p, s;
    logic [31:0] q;
    idx = (longint'(ph) * 1024) >> 32;
    q = 32'((idx << 32) / 1024);
    t = q[30] ? (64'h40000000 - longint'(q[29:0])) : longint'(q[29:0]);
    t15 = t >> 15;
    t2 = (t15 * t15) >> 15;
    p = 21167 - ((t2 * 2611) >> 15);
    p = 51472 - ((t2 * p) >> 15);
    s = (t15 * p) >> 15;
    if (s > 32767) s = 32767;
    return q[31] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint tape_read(bit right_side, longint dly);
    longint pos, base, f, fm1, fm2, fp1, w0, w1, w2, w3, acc;
    longint tap [4];
    pos = (longint'(head_pos) + tfd_pkg::DEPTH - 1) * 65536 - dly;
    base = pos >>> 16;
    f = pos & 64'hFFFF;
    fm1 = f - 65536;
    fm2 = f - 131072;
    fp1 = f + 65536;
    w0 = (-f * fm1 * fm2) / (longint'(6) << 32);
    w1 = (fp1 * fm1 * fm2) / (longint'(2) << 32);
    w2 = (-fp1 * f * fm2) / (longint'(2) << 32);
    w3 = (fp1 * f * fm1) / (longint'(6) << 32);
    for (int k = 0; k < 4; k++) begin
      tap[k] = right_side ? right_tape[12'(base + tfd_pkg::DEPTH - 1 + k)]
                          : left_tape[12'(base + tfd_pkg::DEPTH - 1 + k)];
    end
    acc = tap[0] * w0 + tap[1] * w1 + tap[2] * w2 + tap[3] * w3;
    return clip24(acc / 65536);
  endfunction

  function automatic stereo_t flutter_pair(logic signed [23:0] l, logic signed [23:0] r);
    longint offset, nz, dly, lo, ro;
    stereo_t res;
    left_tape[head_pos] = l;
    right_tape[head_pos] = r;
    head_pos = head_pos + 1'b1;
    offset = 0;
    for (int i = 0; i < 2; i++) begin
      offset += mul_tz(amp_mirror[i], sine_of(phase_mirror[i]), 15);
      phase_mirror[i] = phase_mirror[i] + step_mirror[i];
    end
    nz = xorshift_draw(scrape_seed);
    scrape_lp = clip24(scrape_lp + mul_tz(scrape_coef_mirror, nz - scrape_lp, 16));
    offset += mul_tz(scrape_amp_mirror, scrape_lp, 23);
    offset = mul_tz(offset, depth_mirror, 16);
    dly = longint'(tfd_pkg::NOMINAL) * 65536 + offset;
    if (dly < 2 * 65536) dly = 2 * 65536;
    if (dly > longint'(tfd_pkg::DEPTH - 3) * 65536) begin
      dly = longint'(tfd_pkg::DEPTH - 3) * 65536;
    end
    lo = tape_read(1'b0, dly);
    ro = tape_read(1'b1, dly);
    if (hiss_mirror != 0) begin
      lo = clip24(lo + mul_tz(hiss_mirror, xorshift_draw(left_seed), 16));
      ro = clip24(ro + mul_tz(hiss_mirror, xorshift_draw(right_seed), 16));
    end
    res.left = 24'(lo);
    res.right = 24'(ro);
    return res;
  endfunction

  task automatic reset_mirror();
    for (int i = 0; i < 2; i++) begin
      step_mirror[i] = '0;
      amp_mirror[i] = 0;
      phase_mirror[i] = '0;
    end
    scrape_amp_mirror = 0;
    scrape_coef_mirror = 0;
    depth_mirror = 0;
    hiss_mirror = 0;
    for (int i = 0; i < tfd_pkg::DEPTH; i++) begin
      left_tape[i] = '0;
      right_tape[i] = '0;
    end
    head_pos = '0;
    scrape_lp = 0;
    left_seed = tfd_pkg::LEFT_SEED;
    right_seed = tfd_pkg::RIGHT_SEED;
    scrape_seed = tfd_pkg::SCRAPE_SEED;
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      tfd_pkg::REG_TONE0_STEP: step_mirror[0] = val;
      tfd_pkg::REG_TONE0_AMP: amp_mirror[0] = longint'(val[23:0]);
      tfd_pkg::REG_TONE1_STEP: step_mirror[1] = val;
      tfd_pkg::REG_TONE1_AMP: amp_mirror[1] = longint'(val[23:0]);
      tfd_pkg::REG_SCRAPE_AMP: scrape_amp_mirror = longint'(val[23:0]);
      tfd_pkg::REG_SCRAPE_COEF: scrape_coef_mirror = longint'(val[15:0]);
      tfd_pkg::REG_DEPTH: begin
        depth_mirror = (val[16:0] > 17'd65536) ? 65536 : longint'(val[16:0]);
      end
      tfd_pkg::REG_HISS_GAIN: hiss_mirror = longint'(val[15:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in <= l;
    right_in <= r;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    pending_pairs.push_back(flutter_pair(l, r));
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [23:0] random_sample();
    case ($urandom_range(9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(511)) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_pair(random_sample(), random_sample());
  endtask

  task automatic test_quiet_line();
    logic signed [23:0] marks [8];
    marks = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF,
              24'sh000001, 24'sh555555, 24'shAAAAAA, 24'sh400000};
    for (int i = 0; i < 8; i++) send_pair(marks[i], marks[7 - i]);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(tfd_pkg::REG_TONE0_STEP, 32'hFFFFFFFF);
    write_reg(tfd_pkg::REG_TONE0_AMP, 32'h00FFFFFF);
    write_reg(tfd_pkg::REG_TONE1_STEP, 32'h40000000);
    write_reg(tfd_pkg::REG_TONE1_AMP, 32'h00FFFFFF);
    write_reg(tfd_pkg::REG_SCRAPE_AMP, 32'h00FFFFFF);
    write_reg(tfd_pkg::REG_SCRAPE_COEF, 32'h0000FFFF);
    write_reg(tfd_pkg::REG_DEPTH, 32'h0001FFFF);
    write_reg(tfd_pkg::REG_HISS_GAIN, 32'h0000FFFF);
    for (int idx = 8; idx < 16; idx++) write_reg(4'(idx), $urandom);
    for (int i = 0; i < 8; i++) send_pair(24'sh7FFFFF, 24'sh800000);
    send_random(8);
    drain();
    write_reg(tfd_pkg::REG_DEPTH, 32'h00010001);
    write_reg(tfd_pkg::REG_HISS_GAIN, 32'h0);
    write_reg(tfd_pkg::REG_SCRAPE_COEF, 32'h0);
    send_random(60);
    drain();
  endtask

  task automatic randomize_registers();
    write_reg(tfd_pkg::REG_TONE0_STEP, $urandom);
    write_reg(tfd_pkg::REG_TONE0_AMP, $urandom_range(0, 32'hFFFFFF));
    write_reg(tfd_pkg::REG_TONE1_STEP, $urandom_range(0, 32'h01000000));
    write_reg(tfd_pkg::REG_TONE1_AMP, $urandom_range(0, 32'h3FFFFF));
    write_reg(tfd_pkg::REG_SCRAPE_AMP, $urandom_range(0, 32'hFFFFFF));
    write_reg(tfd_pkg::REG_SCRAPE_COEF, $urandom_range(0, 32'hFFFF));
    write_reg(tfd_pkg::REG_DEPTH,
              ($urandom_range(3) == 0) ? 32'h0 : $urandom_range(0, 32'h1FFFF));
    write_reg(tfd_pkg::REG_HISS_GAIN,
              ($urandom_range(2) == 0) ? 32'h0 : $urandom_range(0, 32'hFFFF));
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      randomize_registers();
      send_random(per_phase);
      drain();
    end
  endtask

  task automatic test_output_stall();
    randomize_registers();
    hold_left = 3000;
    send_random(150);
    drain();
  endtask

  initial begin
    reset_mirror();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 38;
    recv_idle = 68;
    test_quiet_line();
    test_register_extremes();
    test_random_settings(3, 140);
    send_idle = 68;
    recv_idle = 38;
    test_random_settings(3, 140);
    send_idle = 0;
    recv_idle = 0;
    test_output_stall();
    test_random_settings(2, 150);
    $display("Covered %0d stereo items and %0d checked outputs across register settings,",
             items_sent, pairs_checked);
    $display("including clamped delays, hiss on and off, and a long output stall.");
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tfd_pkg.sv
rtl/tfd_ram.sv
rtl/tape_flutter_delay.sv
tb/tape_flutter_delay_test.sv
